[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int PRIO_W       = 8;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int ENTRY_W      = DATA_W + PRIO_W;

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } spq_func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } spq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_DEL_RD,
        ST_RESP
    } spq_state_t;

    typedef struct packed {
        spq_status_t               status;
        logic signed [DATA_W-1:0]  removed_data;
        logic        [PRIO_W-1:0]  removed_priority;
        logic        [COUNT_W-1:0] entry_count;
    } spq_result_t;

endpackage

[rtl/core/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// valid/ready channels for queue commands and queue responses
// ----------------------------------------------------------------------------
interface spq_in_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic signed [DATA_W-1:0] item_data;
    logic        [PRIO_W-1:0] item_priority;

    modport source (output valid, input ready, output func, output item_data,
                    output item_priority);
    modport sink   (input valid, output ready, input func, input item_data,
                    input item_priority);
endinterface

interface spq_out_if
    import spq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic        [STATUS_W-1:0] status;
    logic signed [DATA_W-1:0]  removed_data;
    logic        [PRIO_W-1:0]  removed_priority;
    logic        [COUNT_W-1:0] entry_count;

    modport source (output valid, input ready, output status, output removed_data,
                    output removed_priority, output entry_count);
    modport sink   (input valid, output ready, input status, input removed_data,
                    input removed_priority, input entry_count);
endinterface

[rtl/core/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue, lowest priority value served first
//
// cmd carries one transaction per operation: func selects insert or delete,
// item_data and item_priority give the entry to insert. rsp returns exactly
// one transaction per command with status, the removed entry on a delete
// and the number of entries held afterwards.
// entries sit in one ram as a circular list in sorted order from the head;
// equal priorities keep arrival order.
// overflow and underflow go straight to the response; an insert into an
// empty queue writes at the tail, a delete reads the head entry, and any
// other insert walks back from the tail and moves every held entry with a
// strictly larger priority down one slot (one ram read and write per moved
// slot) before it writes the new entry into the hole.
// cmd is taken again in the cycle after the response is registered.
// reset empties the queue at once; ram contents are not cleared.
// a stalled receiver holds the response register; the next command is still
// accepted and runs up to its own response, which then waits for the slot.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    cmd,
    spq_out_if.source rsp
);

    localparam int PW = $clog2(CAPACITY);

    logic               res_free;
    logic               res_valid;
    spq_result_t        res;
    logic               mem_rd_en;
    logic [PW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [PW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res_free    (res_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    spq_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .rsp       (rsp)
    );

endmodule

[rtl/core/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer that keeps the ram sorted as a circular list from the head
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    spq_in_if.sink                      cmd,
    input  logic                        res_free,
    output logic                        res_valid,
    output spq_result_t                 res,
    output logic                        mem_rd_en,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    input  logic [ENTRY_W-1:0]          mem_rd_data,
    output logic                        mem_wr_en,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [ENTRY_W-1:0]          mem_wr_data
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    spq_state_t               state_reg, state_next;
    logic [PW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [PW-1:0]            hole_reg, hole_next;
    logic [PW-1:0]            prev_reg, prev_next;
    logic [CW-1:0]            left_reg, left_next;
    logic signed [DATA_W-1:0] new_data_reg, new_data_next;
    logic [PRIO_W-1:0]        new_prio_reg, new_prio_next;
    spq_status_t              status_reg, status_next;
    logic signed [DATA_W-1:0] rm_data_reg, rm_data_next;
    logic [PRIO_W-1:0]        rm_prio_reg, rm_prio_next;

    logic [PW:0]              tail_sum;
    logic [PW-1:0]            tail;
    logic                     full;
    logic                     empty;
    logic [PRIO_W-1:0]        rd_prio;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(CAPACITY - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PW'(CAPACITY - 1) : p - PW'(1);
    endfunction

    // physical slot just past the last held entry
    assign tail_sum = (PW+1)'(head_reg) + (PW+1)'(count_reg);
    assign tail     = (tail_sum >= (PW+1)'(CAPACITY)) ?
                      PW'(tail_sum - (PW+1)'(CAPACITY)) : PW'(tail_sum);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign rd_prio  = mem_rd_data[PRIO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        prev_reg     <= prev_next;
        left_reg     <= left_next;
        new_data_reg <= new_data_next;
        new_prio_reg <= new_prio_next;
        status_reg   <= status_next;
        rm_data_reg  <= rm_data_next;
        rm_prio_reg  <= rm_prio_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        hole_next     = hole_reg;
        prev_next     = prev_reg;
        left_next     = left_reg;
        new_data_next = new_data_reg;
        new_prio_next = new_prio_reg;
        status_next   = status_reg;
        rm_data_next  = rm_data_reg;
        rm_prio_next  = rm_prio_reg;
        cmd.ready     = 1'b0;
        res_valid     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = head_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = hole_reg;
        mem_wr_data   = {new_data_reg, new_prio_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    new_data_next = cmd.item_data;
                    new_prio_next = cmd.item_priority;
                    status_next   = STATUS_OK;
                    rm_data_next  = '0;
                    rm_prio_next  = '0;
                    if (spq_func_t'(cmd.func) == FUNC_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = STATUS_OVERFLOW;
                            state_next  = ST_RESP;
                        end
                        else if (empty)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = tail;
                            mem_wr_data = {cmd.item_data, cmd.item_priority};
                            count_next  = count_reg + CW'(1);
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            // walk back from the tail, opening a hole
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = ptr_dec(tail);
                            hole_next   = tail;
                            prev_next   = ptr_dec(tail);
                            left_next   = count_reg;
                            state_next  = ST_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (empty)
                        begin
                            status_next = STATUS_UNDERFLOW;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_reg;
                            state_next  = ST_DEL_RD;
                        end
                    end
                end
            end

            ST_INS_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = hole_reg;
                if (rd_prio > new_prio_reg)
                begin
                    // strictly later priority moves down one slot
                    mem_wr_data = mem_rd_data;
                    hole_next   = prev_reg;
                    left_next   = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ptr_dec(prev_reg);
                        prev_next   = ptr_dec(prev_reg);
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_RESP;
                end
            end

            ST_INS_PUT:
            begin
                mem_wr_en  = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = ST_RESP;
            end

            ST_DEL_RD:
            begin
                rm_data_next = mem_rd_data[ENTRY_W-1:PRIO_W];
                rm_prio_next = rd_prio;
                head_next    = ptr_inc(head_reg);
                count_next   = count_reg - CW'(1);
                state_next   = ST_RESP;
            end

            ST_RESP:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status           = status_reg;
        res.removed_data     = rm_data_reg;
        res.removed_priority = rm_prio_reg;
        res.entry_count      = COUNT_W'(count_reg);
    end

endmodule

[rtl/core/spq_out_stage.sv]
// ----------------------------------------------------------------------------
// spq_out_stage
// response register that holds a result until the receiver takes it
// ----------------------------------------------------------------------------
module spq_out_stage
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  spq_result_t res,
    output logic        res_free,
    spq_out_if.source   rsp
);

    logic        valid_reg, valid_next;
    spq_result_t data_reg;

    assign res_free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid            = valid_reg;
    assign rsp.status           = data_reg.status;
    assign rsp.removed_data     = data_reg.removed_data;
    assign rsp.removed_priority = data_reg.removed_priority;
    assign rsp.entry_count      = data_reg.entry_count;

endmodule
